@@ sv/mps_pkg.sv @@
// Package for the streaming mean pooling block: field widths, register
// indexes, reset values and the result record type.
// No dependencies; imported by mean_pooling_stream, mps_checker and the testbench.
`default_nettype none

package mps_pkg;

    localparam int SAMPLE_W   = 16;  // signed Q8.8 sample and mean
    localparam int QUOT_W     = SAMPLE_W + 1;  // magnitude of a mean, up to 2^15
    localparam int OUT_IDX_W  = 8;   // pooled row and column indexes
    localparam int DIM_CFG_W  = 9;   // image_rows and image_cols registers
    localparam int POOL_CFG_W = 4;   // pool_size register
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [DIM_CFG_W-1:0]  ROWS_RESET = 9'd28;
    localparam logic [DIM_CFG_W-1:0]  COLS_RESET = 9'd28;
    localparam logic [POOL_CFG_W-1:0] POOL_RESET = 4'd2;

    // Result queue in front of the output port.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;
    localparam int FIFO_CNT_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_ROWS = 2'd0,
        CFG_IMAGE_COLS = 2'd1,
        CFG_POOL_SIZE  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]  mean_value;
        logic        [OUT_IDX_W-1:0] out_row;
        logic        [OUT_IDX_W-1:0] out_col;
        logic                        last_of_image;
    } t_result;

endpackage

`default_nettype wire

@@ sv/mean_pooling_stream.sv @@
// Streaming 2-D average pooling over non-overlapping square windows.
// Depends on mps_pkg for widths, register indexes and the result record.
// Usage:
//   Samples enter on the input channel (i_in_valid / o_in_ready, i_sample),
//   one item per sample, in column-major order with the row index running
//   fastest; images follow one another with no gap. Each completed window
//   yields one item on the output channel (o_out_valid / i_out_ready) with
//   the mean, its pooled row and column, and a flag on the image's last
//   result. Samples outside the last whole window row or column give none.
//   The configuration channel (i_cfg_valid / o_cfg_ready) writes image_rows,
//   image_cols or pool_size by index; it is always ready, and a write to a
//   known index restarts the current image. Writes are meant for idle time.
// Pipeline and throughput:
//   A window's result passes stages B, C and D into the result queue
//   before it shows on the output. The block takes one item per clock
//   while o_in_ready is high; that rate is set by the per-row sum memory,
//   read in the accept cycle and written back in the next cycle, with the
//   last write forwarded when the next item hits the same row.
// Reset and stalls:
//   Reset restores the register defaults, the position counters and an
//   empty result queue. The sum memory is not cleared: the first sample of
//   every window overwrites its entry. When the receiver stalls, results
//   collect in an eight-deep queue, and o_in_ready drops only once that
//   queue together with the results still in flight could overflow.
`default_nettype none

module mean_pooling_stream
    import mps_pkg::*;
#(
    parameter int MAX_IMAGE_DIM = 256,
    parameter int MAX_POOL      = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Sample input
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic signed [SAMPLE_W-1:0]   i_sample,
    // Result output
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic signed [SAMPLE_W-1:0]        o_mean_value,
    output logic        [OUT_IDX_W-1:0]       o_out_row,
    output logic        [OUT_IDX_W-1:0]       o_out_col,
    output logic                              o_last_of_image,
    // Configuration writes
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic        [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic        [CFG_DATA_W-1:0] i_cfg_data
);

    // Position counters index one row or column of the image.
    localparam int AW  = (MAX_IMAGE_DIM > 2) ? $clog2(MAX_IMAGE_DIM) : 1;
    // Effective image dimension, 1..MAX_IMAGE_DIM.
    localparam int DW  = $clog2(MAX_IMAGE_DIM + 1);
    // Offset inside a window, 0..MAX_POOL-1.
    localparam int PW  = (MAX_POOL > 2) ? $clog2(MAX_POOL) : 1;
    // Effective pool side, 1..MAX_POOL.
    localparam int PVW = $clog2(MAX_POOL + 1);
    // Window-fit arithmetic: base + 2 * pool against a dimension.
    localparam int XW  = ((DW > PVW + 1) ? DW : PVW + 1) + 1;
    // Window sum: one sample times up to MAX_POOL^2 samples.
    localparam int DVW = $clog2(MAX_POOL * MAX_POOL + 1);
    localparam int SW  = SAMPLE_W + $clog2(MAX_POOL * MAX_POOL);
    // Reciprocal scaling: exact floor division for every sum magnitude.
    localparam int K   = SW + DVW;
    localparam int MW  = K + 1;
    localparam int PRW = SW + MW;
    localparam logic [MW:0] ONE_K = (MW + 1)'(1) << K;

    // ------------------------------------------------------------------
    // Configuration registers and their effective (clamped) values.
    // ------------------------------------------------------------------
    logic [DIM_CFG_W-1:0]  r_cfg_rows;
    logic [DIM_CFG_W-1:0]  r_cfg_cols;
    logic [POOL_CFG_W-1:0] r_cfg_pool;
    logic [DW-1:0]         rows_eff;
    logic [DW-1:0]         cols_eff;
    logic [PVW-1:0]        pool_eff;
    logic                  cfg_write;
    logic                  cfg_known;

    // A zero register acts as one; an oversized one saturates.
    always_comb begin
        if (r_cfg_rows == '0) begin
            rows_eff = DW'(1);
        end else if (32'(r_cfg_rows) > 32'(MAX_IMAGE_DIM)) begin
            rows_eff = DW'(MAX_IMAGE_DIM);
        end else begin
            rows_eff = DW'(r_cfg_rows);
        end
        if (r_cfg_cols == '0) begin
            cols_eff = DW'(1);
        end else if (32'(r_cfg_cols) > 32'(MAX_IMAGE_DIM)) begin
            cols_eff = DW'(MAX_IMAGE_DIM);
        end else begin
            cols_eff = DW'(r_cfg_cols);
        end
        if (r_cfg_pool == '0) begin
            pool_eff = PVW'(1);
        end else if (32'(r_cfg_pool) > 32'(MAX_POOL)) begin
            pool_eff = PVW'(MAX_POOL);
        end else begin
            pool_eff = PVW'(r_cfg_pool);
        end
    end

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_comb begin
        case (i_cfg_index)
            CFG_IMAGE_ROWS: cfg_known = 1'b1;
            CFG_IMAGE_COLS: cfg_known = 1'b1;
            CFG_POOL_SIZE:  cfg_known = 1'b1;
            default:        cfg_known = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rows <= ROWS_RESET;
            r_cfg_cols <= COLS_RESET;
            r_cfg_pool <= POOL_RESET;
        end else if (cfg_write) begin
            case (i_cfg_index)
                CFG_IMAGE_ROWS: r_cfg_rows <= i_cfg_data;
                CFG_IMAGE_COLS: r_cfg_cols <= i_cfg_data;
                CFG_POOL_SIZE:  r_cfg_pool <= i_cfg_data[POOL_CFG_W-1:0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Position tracking. Instead of dividing the position by the pool
    // side, each axis keeps its offset inside the window, the pooled index
    // and the first image row or column of the current window.
    // ------------------------------------------------------------------
    logic [AW-1:0] r_row, r_rbase, r_orow;
    logic [PW-1:0] r_rin;
    logic [AW-1:0] r_col, r_cbase, r_ocol;
    logic [PW-1:0] r_cin;

    logic [DW-1:0] row_p1, col_p1;
    logic          row_wrap, col_wrap;
    logic          rin_wrap, cin_wrap;
    logic          row_fit, col_fit;
    logic          row_last, col_last;
    logic          in_accept;

    assign row_p1   = DW'(r_row) + DW'(1);
    assign col_p1   = DW'(r_col) + DW'(1);
    assign row_wrap = (row_p1 >= rows_eff);
    assign col_wrap = (col_p1 >= cols_eff);
    assign rin_wrap = ((PVW'(r_rin) + PVW'(1)) == pool_eff);
    assign cin_wrap = ((PVW'(r_cin) + PVW'(1)) == pool_eff);

    // A window counts only if it lies wholly inside the image; it is the
    // last one on its axis when the following window would not fit.
    assign row_fit  = (XW'(r_rbase) + XW'(pool_eff)) <= XW'(rows_eff);
    assign col_fit  = (XW'(r_cbase) + XW'(pool_eff)) <= XW'(cols_eff);
    assign row_last = (XW'(r_rbase) + XW'({pool_eff, 1'b0})) > XW'(rows_eff);
    assign col_last = (XW'(r_cbase) + XW'({pool_eff, 1'b0})) > XW'(cols_eff);

    assign in_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (cfg_write && cfg_known)) begin
            r_row   <= '0;
            r_rin   <= '0;
            r_rbase <= '0;
            r_orow  <= '0;
            r_col   <= '0;
            r_cin   <= '0;
            r_cbase <= '0;
            r_ocol  <= '0;
        end else if (in_accept) begin
            if (row_wrap) begin
                // End of a column: rows start over, the column advances.
                r_row   <= '0;
                r_rin   <= '0;
                r_rbase <= '0;
                r_orow  <= '0;
                if (col_wrap) begin
                    r_col   <= '0;
                    r_cin   <= '0;
                    r_cbase <= '0;
                    r_ocol  <= '0;
                end else begin
                    r_col <= AW'(col_p1);
                    if (cin_wrap) begin
                        r_cin   <= '0;
                        r_cbase <= AW'(col_p1);
                        r_ocol  <= r_ocol + AW'(1);
                    end else begin
                        r_cin <= r_cin + PW'(1);
                    end
                end
            end else begin
                r_row <= AW'(row_p1);
                if (rin_wrap) begin
                    r_rin   <= '0;
                    r_rbase <= AW'(row_p1);
                    r_orow  <= r_orow + AW'(1);
                end else begin
                    r_rin <= r_rin + PW'(1);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Reciprocal table: ceil(2^K / p^2) for every pool side.
    // ------------------------------------------------------------------
    logic [MW-1:0] recip_tab [MAX_POOL];

    for (genvar g = 0; g < MAX_POOL; g++) begin : g_recip
        localparam longint unsigned DIV   = longint'((g + 1) * (g + 1));
        localparam logic [MW:0]     RECIP = (MW + 1)'((ONE_K + DIV - 1) / DIV);
        assign recip_tab[g] = MW'(RECIP);
    end

    // ------------------------------------------------------------------
    // Stage A (accept): read the row's running sum.
    // Stage B: add the sample, write it back, take the magnitude.
    // Stage C: multiply by the reciprocal.
    // Stage D: scale, restore the sign, push into the result queue.
    // ------------------------------------------------------------------
    logic signed [SW-1:0] r_sum_mem [MAX_IMAGE_DIM];
    logic signed [SW-1:0] r_rd_data;

    logic                       r_s1_valid;
    logic                       r_s1_first;
    logic                       r_s1_emit;
    logic                       r_s1_last;
    logic signed [SAMPLE_W-1:0] r_s1_sample;
    logic        [AW-1:0]       r_s1_addr;
    logic        [AW-1:0]       r_s1_col;

    logic                       r_fwd_valid;
    logic        [AW-1:0]       r_fwd_addr;
    logic signed [SW-1:0]       r_fwd_data;

    logic                       r_s2_valid;
    logic        [SW-1:0]       r_s2_mag;
    logic                       r_s2_neg;
    logic        [MW-1:0]       r_s2_recip;
    logic        [AW-1:0]       r_s2_row;
    logic        [AW-1:0]       r_s2_col;
    logic                       r_s2_last;

    logic                       r_s3_valid;
    logic        [PRW-1:0]      r_s3_prod;
    logic                       r_s3_neg;
    logic        [AW-1:0]       r_s3_row;
    logic        [AW-1:0]       r_s3_col;
    logic                       r_s3_last;

    logic signed [SW-1:0]       old_sum;
    logic signed [SW-1:0]       new_sum;
    logic        [SW-1:0]       sum_mag;
    logic        [QUOT_W-1:0]   quot;
    logic        [QUOT_W-1:0]   quot_signed;
    t_result                    push_item;

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_sum_mem[r_orow];
        if (r_s1_valid) begin
            r_sum_mem[r_s1_addr] <= new_sum;
        end
    end

    // The write from the previous item lands on the same edge as this
    // item's read, so the most recent write is forwarded on an address hit.
    assign old_sum = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_data : r_rd_data;
    assign new_sum = r_s1_first ? SW'(r_s1_sample) : (old_sum + SW'(r_s1_sample));
    assign sum_mag = new_sum[SW-1] ? SW'(-new_sum) : SW'(new_sum);

    assign quot        = r_s3_prod[K +: QUOT_W];
    assign quot_signed = r_s3_neg ? (~quot + QUOT_W'(1)) : quot;

    always_comb begin
        push_item.mean_value    = quot_signed[SAMPLE_W-1:0];
        push_item.out_row       = OUT_IDX_W'(r_s3_row);
        push_item.out_col       = OUT_IDX_W'(r_s3_col);
        push_item.last_of_image = r_s3_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
        end else begin
            r_s1_valid <= in_accept && row_fit && col_fit;
            if (r_s1_valid) begin
                r_fwd_valid <= 1'b1;
            end
            r_s2_valid <= r_s1_valid && r_s1_emit;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_first  <= (r_rin == '0) && (r_cin == '0);
        r_s1_emit   <= rin_wrap && cin_wrap;
        r_s1_last   <= row_last && col_last;
        r_s1_sample <= i_sample;
        r_s1_addr   <= r_orow;
        r_s1_col    <= r_ocol;

        if (r_s1_valid) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= new_sum;
        end

        r_s2_mag   <= sum_mag;
        r_s2_neg   <= new_sum[SW-1];
        r_s2_recip <= recip_tab[PW'(pool_eff - PVW'(1))];
        r_s2_row   <= r_s1_addr;
        r_s2_col   <= r_s1_col;
        r_s2_last  <= r_s1_last;

        r_s3_prod <= PRW'(r_s2_mag) * PRW'(r_s2_recip);
        r_s3_neg  <= r_s2_neg;
        r_s3_row  <= r_s2_row;
        r_s3_col  <= r_s2_col;
        r_s3_last <= r_s2_last;
    end

    // ------------------------------------------------------------------
    // Result queue. Input is held off once the queued results plus those
    // still in the pipeline leave no room for one more.
    // ------------------------------------------------------------------
    t_result               r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_fifo_cnt;
    logic [FIFO_CNT_W-1:0] n_fifo_cnt;
    logic [FIFO_CNT_W-1:0] in_flight;
    logic                  fifo_pop;
    t_result               head_item;

    assign in_flight = FIFO_CNT_W'(r_s1_valid && r_s1_emit)
                     + FIFO_CNT_W'(r_s2_valid)
                     + FIFO_CNT_W'(r_s3_valid);
    assign o_in_ready = (r_fifo_cnt + in_flight) < FIFO_CNT_W'(FIFO_DEPTH);

    assign fifo_pop = o_out_valid && i_out_ready;

    always_comb begin
        n_fifo_cnt = r_fifo_cnt;
        if (r_s3_valid && !fifo_pop) begin
            n_fifo_cnt = r_fifo_cnt + FIFO_CNT_W'(1);
        end else if (!r_s3_valid && fifo_pop) begin
            n_fifo_cnt = r_fifo_cnt - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
        end else begin
            r_fifo_cnt <= n_fifo_cnt;
            if (r_s3_valid) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (fifo_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s3_valid) begin
            r_fifo[r_wr_ptr] <= push_item;
        end
    end

    assign head_item       = r_fifo[r_rd_ptr];
    assign o_out_valid     = (r_fifo_cnt != '0);
    assign o_mean_value    = head_item.mean_value;
    assign o_out_row       = head_item.out_row;
    assign o_out_col       = head_item.out_col;
    assign o_last_of_image = head_item.last_of_image;

endmodule

`default_nettype wire

@@ sv/mps_checker.sv @@
// Port-level checks for mean_pooling_stream, attached by the bind below.
// Depends on mps_pkg for field widths.
`default_nettype none

module mps_checker
    import mps_pkg::*;
(
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_ready,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_ready,
    input wire logic signed [SAMPLE_W-1:0]   o_mean_value,
    input wire logic        [OUT_IDX_W-1:0]  o_out_row,
    input wire logic        [OUT_IDX_W-1:0]  o_out_col,
    input wire logic                         o_last_of_image
);

    // A stalled result stays offered with the same contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_mean_value)
            && $stable(o_out_row) && $stable(o_out_col) && $stable(o_last_of_image))
        else $error("result changed or vanished while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

    // A result queue that starts to fill was fed by an item taken earlier
    // and carried through pipeline stages B, C and D into the queue.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 4))
        else $error("result appeared without a matching input item");

    // Input is only held off while results are waiting downstream.
    a_ready_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input held off with no result pending");

endmodule

bind mean_pooling_stream mps_checker u_mps_checker (.*);

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the streaming mean pooling block.
// Depends on mps_pkg and mean_pooling_stream; drives random valid/ready traffic,
// predicts every window mean in SystemVerilog and checks results in order.
`timescale 1ns / 1ps

module testbench;
    import mps_pkg::*;

    localparam int IMAGE_DIM_MAX = 256;
    localparam int POOL_MAX      = 8;
    localparam int RANDOM_ITEMS  = 1600;
    // The block registers each result through its pipeline before showing it;
    // this leaves room for that plus its internal queue before a register write.
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 100;

    // Index 3 is not a register; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic {
        STEP_WRITE,
        STEP_SAMPLE
    } t_step_kind;

    typedef struct packed {
        t_step_kind             kind;
        logic [CFG_IDX_W-1:0]   index;
        logic [CFG_DATA_W-1:0]  data;
        logic [SAMPLE_W-1:0]    value;
        logic                   typed;
        t_result                want;
    } t_step;

    localparam t_result NONE = '0;
    localparam int DIRECTED_LEN = 38;

    // Directed opening. Rows with typed set carry a result that is obvious
    // by hand; the rest are checked against the window predictor.
    localparam t_step DIRECTED [DIRECTED_LEN] = '{
        // 2x2 image, 2x2 window: each image yields one result.
        '{STEP_WRITE,  CFG_IMAGE_ROWS, 9'd2,  16'h0000, 1'b0, NONE},
        '{STEP_WRITE,  CFG_IMAGE_COLS, 9'd2,  16'h0000, 1'b0, NONE},
        '{STEP_WRITE,  CFG_POOL_SIZE,  9'd2,  16'h0000, 1'b0, NONE},
        // Largest positive sample everywhere.
        '{STEP_SAMPLE, CFG_IMAGE_ROWS, 9'd0,  16'h7FFF, 1'b0, NONE},
        '{STEP_SAMPLE, CFG_IMAGE_ROWS, 9'd0,  16'h7FFF, 1'b0, NONE},
        '{STEP_SAMPLE, CFG_IMAGE_ROWS, 9'd0,  16'h7FFF, 1'b0, NONE},
        '{STEP_SAMPLE, CFG_IMAGE_ROWS, 9'd0,  16'h7FFF, 1'b1, '{16'h7FFF, 8'd0, 8'd0, 1'b1}},
        // Most negative sample everywhere, in the next image back to back.
        '{STEP_SAMPLE, CFG_IMAGE_ROWS, 9'd0,  16'h8000, 1'b0, NONE},
        '{STEP_SAMPLE, CFG_IMAGE_ROWS, 9'd0,  16'h8000, 1'b0, NONE},
        '{STEP_SAMPLE, CFG_IMAGE_ROWS, 9'd0,  16'h8000, 1'b0, NONE},
        '{STEP_SAMPLE, CFG_IMAGE_ROWS, 9'd0,  16'h8000, 1'b1, '{16'h8000, 8'd0, 8'd0, 1'b1}},
        // A sum of -5 over four samples truncates toward zero to -1.
        '{STEP_SAMPLE, CFG_IMAGE_ROWS, 9'd0,  16'hFFFB, 1'b0, NONE},
        '{STEP_SAMPLE, CFG_IMAGE_ROWS, 9'd0,  16'h0000, 1'b0, NONE},
        '{STEP_SAMPLE, CFG_IMAGE_ROWS, 9'd0,  16'h0000, 1'b0, NONE},
        '{STEP_SAMPLE, CFG_IMAGE_ROWS, 9'd0,  16'h0000, 1'b1, '{16'hFFFF, 8'd0, 8'd0, 1'b1}},
        // A pool size of zero behaves as one: every sample is a result.
        '{STEP_WRITE,  CFG_POOL_SIZE,  9'd0,  16'h0000, 1'b0, NONE},
        '{STEP_SAMPLE, CFG_IMAGE_ROWS, 9'd0,  16'h0100, 1'b0, NONE},
        '{STEP_SAMPLE, CFG_IMAGE_ROWS, 9'd0,  16'h1234, 1'b0, NONE},
        '{STEP_SAMPLE, CFG_IMAGE_ROWS, 9'd0,  16'h5555, 1'b0, NONE},
        '{STEP_SAMPLE, CFG_IMAGE_ROWS, 9'd0,  16'hAAAA, 1'b1, '{16'hAAAA, 8'd1, 8'd1, 1'b1}},
        // Zero image dimensions behave as one: a 1x1 image.
        '{STEP_WRITE,  CFG_IMAGE_ROWS, 9'd0,  16'h0000, 1'b0, NONE},
        '{STEP_WRITE,  CFG_IMAGE_COLS, 9'd0,  16'h0000, 1'b0, NONE},
        '{STEP_WRITE,  CFG_POOL_SIZE,  9'd1,  16'h0000, 1'b0, NONE},
        '{STEP_SAMPLE, CFG_IMAGE_ROWS, 9'd0,  16'h4000, 1'b1, '{16'h4000, 8'd0, 8'd0, 1'b1}},
        // A write to the spare index in mid-window must not restart the image.
        '{STEP_WRITE,  CFG_IMAGE_ROWS, 9'd2,  16'h0000, 1'b0, NONE},
        '{STEP_WRITE,  CFG_IMAGE_COLS, 9'd2,  16'h0000, 1'b0, NONE},
        '{STEP_WRITE,  CFG_POOL_SIZE,  9'd2,  16'h0000, 1'b0, NONE},
        '{STEP_SAMPLE, CFG_IMAGE_ROWS, 9'd0,  16'h0008, 1'b0, NONE},
        '{STEP_SAMPLE, CFG_IMAGE_ROWS, 9'd0,  16'h0008, 1'b0, NONE},
        '{STEP_WRITE,  CFG_SPARE,      9'h1FF, 16'h0000, 1'b0, NONE},
        '{STEP_SAMPLE, CFG_IMAGE_ROWS, 9'd0,  16'h0008, 1'b0, NONE},
        '{STEP_SAMPLE, CFG_IMAGE_ROWS, 9'd0,  16'h0008, 1'b1, '{16'h0008, 8'd0, 8'd0, 1'b1}},
        // A real register write in mid-window restarts the image.
        '{STEP_SAMPLE, CFG_IMAGE_ROWS, 9'd0,  16'h0100, 1'b0, NONE},
        '{STEP_WRITE,  CFG_IMAGE_ROWS, 9'd2,  16'h0000, 1'b0, NONE},
        '{STEP_SAMPLE, CFG_IMAGE_ROWS, 9'd0,  16'h0004, 1'b0, NONE},
        '{STEP_SAMPLE, CFG_IMAGE_ROWS, 9'd0,  16'h0004, 1'b0, NONE},
        '{STEP_SAMPLE, CFG_IMAGE_ROWS, 9'd0,  16'h0004, 1'b0, NONE},
        '{STEP_SAMPLE, CFG_IMAGE_ROWS, 9'd0,  16'h0004, 1'b1, '{16'h0004, 8'd0, 8'd0, 1'b1}}
    };

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic signed [SAMPLE_W-1:0]   in_sample = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b1;
    logic signed [SAMPLE_W-1:0]   out_mean;
    logic        [OUT_IDX_W-1:0]  out_row;
    logic        [OUT_IDX_W-1:0]  out_col;
    logic                         out_last;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic        [CFG_IDX_W-1:0]  cfg_index = '0;
    logic        [CFG_DATA_W-1:0] cfg_data = '0;

    mean_pooling_stream #(
        .MAX_IMAGE_DIM (IMAGE_DIM_MAX),
        .MAX_POOL      (POOL_MAX)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_sample        (in_sample),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_mean_value    (out_mean),
        .o_out_row       (out_row),
        .o_out_col       (out_col),
        .o_last_of_image (out_last),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Predictor state: the register copies, the position of the next
    // sample and the running sum of the open window in each pooled row.
    logic [DIM_CFG_W-1:0]  geo_rows = ROWS_RESET;
    logic [DIM_CFG_W-1:0]  geo_cols = COLS_RESET;
    logic [POOL_CFG_W-1:0] geo_pool = POOL_RESET;
    int                    pos_row = 0;
    int                    pos_col = 0;
    logic signed [21:0]    row_sums [IMAGE_DIM_MAX];

    t_result pending_means [$];

    int  samples_sent = 0;
    int  means_checked = 0;
    int  reg_writes = 0;
    int  mismatches = 0;
    int  cycles = 0;
    bit  sender_steady = 1'b0;
    bit  taker_steady = 1'b0;
    int  hold;
    int  hold_left = 0;

    // Zero acts as one and oversized values clamp, for dims and pool alike.
    function automatic int eff_size(input int value, input int limit);
        if (value == 0) return 1;
        if (value > limit) return limit;
        return value;
    endfunction

    function automatic int draw_wait(input bit steady);
        if (steady) return 0;
        return ($urandom_range(0, 1) != 0) ? 0 : int'($urandom_range(0, 16));
    endfunction

    // Advances the window predictor by one sample. Returns 1 when the
    // sample closes a window, with the mean and its position in res.
    function automatic bit predict_mean(input logic signed [SAMPLE_W-1:0] s,
                                        output t_result res);
        int rows;
        int cols;
        int p;
        int orow;
        int ocol;
        int mean;
        bit fired;
        rows  = eff_size(geo_rows, IMAGE_DIM_MAX);
        cols  = eff_size(geo_cols, IMAGE_DIM_MAX);
        p     = eff_size(geo_pool, POOL_MAX);
        orow  = pos_row / p;
        ocol  = pos_col / p;
        fired = 1'b0;
        res   = NONE;
        // Samples past the last whole window row or column are dropped.
        if (orow < rows / p && ocol < cols / p) begin
            if (pos_row % p == 0 && pos_col % p == 0) begin
                row_sums[orow] = s;
            end else begin
                row_sums[orow] = row_sums[orow] + s;
            end
            if (pos_row % p == p - 1 && pos_col % p == p - 1) begin
                // Signed division in SystemVerilog truncates toward zero.
                mean              = int'(row_sums[orow]) / (p * p);
                res.mean_value    = mean[SAMPLE_W-1:0];
                res.out_row       = orow[OUT_IDX_W-1:0];
                res.out_col       = ocol[OUT_IDX_W-1:0];
                res.last_of_image = (orow == rows / p - 1) && (ocol == cols / p - 1);
                fired             = 1'b1;
            end
        end
        pos_row++;
        if (pos_row >= rows) begin
            pos_row = 0;
            pos_col++;
            if (pos_col >= cols) begin
                pos_col = 0;
            end
        end
        return fired;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        // Past this many lines a broken block would only flood the log.
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
    endtask

    // Sends one sample after a random gap, waits for it to be taken and
    // queues what the predictor (or the table) says it must produce.
    task automatic push_sample(input logic [SAMPLE_W-1:0] value, input bit typed,
                               input t_result typed_res);
        int      gap;
        bit      fired;
        t_result res;
        gap = draw_wait(sender_steady);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_sample <= value;
        do @(posedge clk); while (!in_ready);
        fired = predict_mean(value, res);
        if (typed) begin
            pending_means.push_back(typed_res);
        end else if (fired) begin
            pending_means.push_back(res);
        end
        samples_sent++;
    endtask

    // Register writes happen only with the block idle: every expected
    // result out, and time for any sample that yields none to drain.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        in_valid <= 1'b0;
        while (pending_means.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            CFG_IMAGE_ROWS: geo_rows = data;
            CFG_IMAGE_COLS: geo_cols = data;
            CFG_POOL_SIZE:  geo_pool = data[POOL_CFG_W-1:0];
            default: return;
        endcase
        // Any known register restarts the image; the sums are kept.
        pos_row = 0;
        pos_col = 0;
    endtask

    // Result side: after each item taken, hold ready low for a random
    // number of cycles, unless this phase runs without stalls.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b1;
            hold_left <= 0;
        end else if (out_valid && out_ready) begin
            hold = draw_wait(taker_steady);
            out_ready <= (hold == 0);
            hold_left <= hold;
        end else if (!out_ready) begin
            if (hold_left <= 1) begin
                out_ready <= 1'b1;
            end
            hold_left <= hold_left - 1;
        end
    end

    // Every result taken is matched against the oldest expected mean.
    always @(posedge clk) begin : check_results
        t_result want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_means.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d at (%0d,%0d)",
                                          out_mean, out_row, out_col));
            end else begin
                want = pending_means.pop_front();
                if (out_mean !== want.mean_value) begin
                    report_mismatch($sformatf("mean at (%0d,%0d): got %0d, expected %0d",
                                              want.out_row, want.out_col, out_mean,
                                              want.mean_value));
                end
                if (out_row !== want.out_row) begin
                    report_mismatch($sformatf("row: got %0d, expected %0d",
                                              out_row, want.out_row));
                end
                if (out_col !== want.out_col) begin
                    report_mismatch($sformatf("column: got %0d, expected %0d",
                                              out_col, want.out_col));
                end
                if (out_last !== want.last_of_image) begin
                    report_mismatch($sformatf("last flag at (%0d,%0d): got %b, expected %b",
                                              want.out_row, want.out_col, out_last,
                                              want.last_of_image));
                end
            end
            means_checked++;
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_means.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        t_step               st;
        int                  base;
        int                  phase;
        int                  kind;
        int                  rows_d;
        int                  cols_d;
        int                  pool_d;
        int                  p;
        int                  image_len;
        int                  n;
        bit                  forced;
        logic [4:0]          pool_hi;
        logic [SAMPLE_W-1:0] s;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i]) begin
            st = DIRECTED[i];
            if (st.kind == STEP_WRITE) begin
                write_reg(st.index, st.data);
            end else begin
                push_sample(st.value, st.typed, st.want);
            end
        end

        // Random phases: each picks a geometry, writes some registers and
        // streams whole images back to back, now and then a partial one
        // that the next register write cuts off. The first two phases are
        // a full-height and a full-width image so the output indexes reach
        // their top bit.
        base  = samples_sent;
        phase = 0;
        while (samples_sent - base < RANDOM_ITEMS) begin
            sender_steady = ($urandom_range(0, 3) == 0);
            taker_steady  = ($urandom_range(0, 3) == 0);
            kind   = (phase < 2) ? phase : int'($urandom_range(2, 19));
            forced = (phase < 2);
            case (kind)
                0: begin
                    rows_d = IMAGE_DIM_MAX;
                    cols_d = 1;
                    pool_d = 1;
                end
                1: begin
                    rows_d = 1;
                    cols_d = IMAGE_DIM_MAX;
                    pool_d = 1;
                end
                2: begin
                    rows_d = $urandom_range(129, 511);
                    cols_d = $urandom_range(0, 1);
                    pool_d = $urandom_range(0, 3);
                end
                3: begin
                    rows_d = $urandom_range(0, 1);
                    cols_d = $urandom_range(129, 511);
                    pool_d = $urandom_range(0, 3);
                end
                4, 5: begin
                    // Window larger than the image: nothing comes out.
                    rows_d = $urandom_range(0, 7);
                    cols_d = $urandom_range(0, 7);
                    pool_d = $urandom_range(8, 15);
                end
                default: begin
                    pool_d = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 15)
                                                         : $urandom_range(0, 4);
                    p      = eff_size(pool_d, POOL_MAX);
                    rows_d = $urandom_range(0, 2 * p + 4);
                    cols_d = $urandom_range(0, 2 * p + 4);
                end
            endcase
            pool_hi = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'd0;
            if (forced || $urandom_range(0, 3) != 0) begin
                write_reg(CFG_IMAGE_ROWS, CFG_DATA_W'(rows_d));
            end
            if (forced || $urandom_range(0, 3) != 0) begin
                write_reg(CFG_IMAGE_COLS, CFG_DATA_W'(cols_d));
            end
            if (forced || $urandom_range(0, 3) != 0) begin
                write_reg(CFG_POOL_SIZE, {pool_hi, 4'(pool_d)});
            end
            if ($urandom_range(0, 7) == 0) begin
                write_reg(CFG_SPARE, CFG_DATA_W'($urandom()));
            end

            image_len = eff_size(geo_rows, IMAGE_DIM_MAX) * eff_size(geo_cols, IMAGE_DIM_MAX);
            n = image_len * ((image_len > 150) ? 1 : int'($urandom_range(1, 3)));
            if (!forced && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, image_len);
            end
            repeat (n) begin
                case ($urandom_range(0, 9))
                    0: s = 16'h7FFF;
                    1: s = 16'h8000;
                    2: s = 16'($urandom_range(0, 16)) - 16'd8;
                    default: s = 16'($urandom());
                endcase
                push_sample(s, 1'b0, NONE);
            end
            phase++;
        end

        in_valid <= 1'b0;
        while (pending_means.size() != 0) @(posedge clk);
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (pending_means.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_means.size()));
        end

        $display("testbench: %0d samples over %0d random geometries, %0d register writes",
                 samples_sent, phase, reg_writes);
        $display("testbench: %0d window means checked, %0d mismatches",
                 means_checked, mismatches);
        if (mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/mps_pkg.sv
sv/mean_pooling_stream.sv
sv/mps_checker.sv
sim/testbench.sv
